### src/uue_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uue_pkg
// Shared types, constants and the character map for the uuencode line encoder.
// ----------------------------------------------------------------------------
package uue_pkg;

  localparam int GROUP_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int STORE_DEPTH = 60;
  localparam int IDX_W       = 6;
  localparam int ACC_W       = 12;
  localparam int BITS_W      = 4;

  localparam logic [IDX_W-1:0]  LINE_CHARS   = 6'd60;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] ZERO_CHAR    = 8'd96;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] MARK_CHAR    = 8'd0;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GROUP = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CH    = 7'b0010000,
    S_NL    = 7'b0100000,
    S_MARK  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [GROUP_W-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } buf_rd_t;

  function automatic logic [CHAR_W-1:0] enc_char(input logic [GROUP_W-1:0] n);
    logic [CHAR_W-1:0] c;
    c = (n == '0) ? ZERO_CHAR : (SPACE_CHAR + {2'b00, n});
    return c;
  endfunction

endpackage

### src/uuencode_line_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuencode_line_encoder_core
// Packs bytes into 6-bit groups, buffers one line and emits it as uuencode
// text: length character, group characters, newline; or a lone null marker.
// ----------------------------------------------------------------------------
//  channel  ports                                   dir  meaning
//  in       in_valid in_stall in_cmd in_data_byte   in   byte or finish
//  out      out_valid out_stall out_char            out  one character
//           out_last_of_run                              per transfer
//
//  A data byte is taken in while idle, then each 6-bit group goes through
//  the shared shifter. A finish adds 2 or 3 padding groups when bits are
//  left over. A line drains as length character, buffered characters (read
//  state, then output state: single read port, registered read), newline.
//  Reset is synchronous and clears control state only; the line buffer is
//  not cleared. out_stall holds the sequencer; in_stall is high while busy.
// ----------------------------------------------------------------------------
module uuencode_line_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last_of_run
);
  import uue_pkg::*;

  state_t              state_r, state_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic [1:0]          grp_left_r, grp_left_nxt;
  logic                fin_r, fin_nxt;
  logic [3:0]          lo_bits_r, lo_bits_nxt;
  logic [2:0]          lo_cnt_r, lo_cnt_nxt;
  logic [IDX_W-1:0]    line_bytes_r, line_bytes_nxt;
  logic [IDX_W-1:0]    line_chars_r, line_chars_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_xfer;
  logic                out_xfer;
  logic                out_free;
  logic [ACC_W-1:0]    shifted;
  logic [GROUP_W-1:0]  group;
  logic                grp_wr;
  logic [IDX_W-1:0]    chars_after;
  logic [IDX_W-1:0]    rd_idx_inc;
  logic [GROUP_W-1:0]  rd_data;
  buf_wr_t             buf_wr;
  buf_rd_t             buf_rd;

  uue_line_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd      (buf_rd),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // shared group extractor; once the real bits run out the padding is zero
  assign shifted     = acc_r >> (bits_r - 4'd6);
  assign group       = (bits_r >= 4'd6) ? shifted[GROUP_W-1:0] : '0;
  assign grp_wr      = (state_r == S_GROUP) && (line_chars_r < 6'(STORE_DEPTH));
  assign chars_after = line_chars_r + {5'b0, grp_wr};
  assign rd_idx_inc  = rd_idx_r + 6'd1;

  always_comb begin
    buf_wr.en   = grp_wr;
    buf_wr.addr = line_chars_r;
    buf_wr.data = group;
    buf_rd.en   = (state_r == S_RD);
    buf_rd.addr = rd_idx_r;
  end

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    bits_nxt       = bits_r;
    grp_left_nxt   = grp_left_r;
    fin_nxt        = fin_r;
    lo_bits_nxt    = lo_bits_r;
    lo_cnt_nxt     = lo_cnt_r;
    line_bytes_nxt = line_bytes_r;
    line_chars_nxt = line_chars_r;
    rd_idx_nxt     = rd_idx_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_xfer ? 1'b0 : out_valid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          bits_nxt = 4'(lo_cnt_r) + 4'd8;
          if (in_cmd == CMD_DATA) begin
            acc_nxt        = {lo_bits_r, in_data_byte};
            grp_left_nxt   = (lo_cnt_r == 3'd4) ? 2'd2 : 2'd1;
            fin_nxt        = 1'b0;
            line_bytes_nxt = line_bytes_r + 6'd1;
            state_nxt      = S_GROUP;
            unique case (lo_cnt_r)
              3'd0: begin
                lo_cnt_nxt  = 3'd2;
                lo_bits_nxt = {2'b00, in_data_byte[1:0]};
              end
              3'd2: begin
                lo_cnt_nxt  = 3'd4;
                lo_bits_nxt = in_data_byte[3:0];
              end
              default: begin
                lo_cnt_nxt  = 3'd0;
                lo_bits_nxt = 4'd0;
              end
            endcase
          end else begin
            acc_nxt      = {lo_bits_r, 8'd0};
            grp_left_nxt = (lo_cnt_r == 3'd2) ? 2'd3 : 2'd2;
            fin_nxt      = 1'b1;
            lo_cnt_nxt   = 3'd0;
            lo_bits_nxt  = 4'd0;
            if (lo_cnt_r != 3'd0) begin
              state_nxt = S_GROUP;
            end else if (line_bytes_r == '0) begin
              state_nxt = S_MARK;
            end else begin
              state_nxt = S_LEN;
            end
          end
        end
      end

      S_GROUP: begin
        line_chars_nxt = chars_after;
        bits_nxt       = (bits_r >= 4'd6) ? (bits_r - 4'd6) : bits_r;
        grp_left_nxt   = grp_left_r - 2'd1;
        if (grp_left_r == 2'd1) begin
          if (fin_r) begin
            state_nxt = (line_bytes_r == '0) ? S_MARK : S_LEN;
          end else if (lo_cnt_r == 3'd0 && chars_after >= LINE_CHARS) begin
            state_nxt = S_LEN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_LEN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = enc_char(line_bytes_r);
          out_last_nxt  = 1'b0;
          rd_idx_nxt    = '0;
          state_nxt     = (line_chars_r == '0) ? S_NL : S_RD;
        end
      end

      S_RD: begin
        state_nxt = S_CH;
      end

      S_CH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = enc_char(rd_data);
          out_last_nxt  = 1'b0;
          rd_idx_nxt    = rd_idx_inc;
          state_nxt     = (rd_idx_inc >= line_chars_r) ? S_NL : S_RD;
        end
      end

      S_NL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = NEWLINE_CHAR;
          out_last_nxt   = 1'b1;
          line_bytes_nxt = '0;
          line_chars_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end

      S_MARK: begin
        // finish on an empty line: single null marker
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = MARK_CHAR;
          out_last_nxt   = 1'b1;
          line_chars_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grp_left_r   <= '0;
      fin_r        <= 1'b0;
      lo_bits_r    <= '0;
      lo_cnt_r     <= '0;
      line_bytes_r <= '0;
      line_chars_r <= '0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      grp_left_r   <= grp_left_nxt;
      fin_r        <= fin_nxt;
      lo_bits_r    <= lo_bits_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
      line_bytes_r <= line_bytes_nxt;
      line_chars_r <= line_chars_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    bits_r     <= bits_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

endmodule

### src/uue_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uue_line_buf
// Line buffer for 6-bit groups: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uue_line_buf (
  input  logic                  clk,
  input  uue_pkg::buf_wr_t      wr,
  input  uue_pkg::buf_rd_t      rd,
  output logic [5:0]            rd_data
);
  import uue_pkg::*;

  logic [GROUP_W-1:0] mem [STORE_DEPTH];
  logic [GROUP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bytes and finish commands into the uuencode line encoder with bursty
// input and a changing output stall pattern. Each character that comes out is
// compared against a software line encoder that tracks the packed bits, the
// buffered groups and the byte count of the current line.
// ----------------------------------------------------------------------------
module testbench;
  import uue_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       drain;  // hold the sender until every expected char is back
  } stim_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_cmd;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_last_of_run;

  stim_t pending_items[$];
  char_t expected_chars[$];
  int    pending_n;
  int    fail_count;
  int    burst_left;
  int    gap_left;
  int    stall_mode;
  int    stall_left;

  // encoder state mirrored from the block
  logic [3:0]         enc_left_bits;
  logic [2:0]         enc_left_cnt;
  logic [5:0]         enc_line_bytes;
  int                 enc_line_chars;
  logic [GROUP_W-1:0] enc_store [STORE_DEPTH];

  uuencode_line_encoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] group_char(input logic [5:0] g);
    return (g == 6'd0) ? ZERO_CHAR : (SPACE_CHAR + {2'b00, g});
  endfunction

  task automatic store_group(input logic [5:0] g);
    if (enc_line_chars < STORE_DEPTH) begin
      enc_store[enc_line_chars] = g;
      enc_line_chars++;
    end
  endtask

  task automatic push_line();
    expected_chars.push_back(char_t'{group_char(enc_line_bytes), 1'b0});
    for (int i = 0; i < enc_line_chars; i++)
      expected_chars.push_back(char_t'{group_char(enc_store[i]), 1'b0});
    expected_chars.push_back(char_t'{NEWLINE_CHAR, 1'b1});
    enc_line_bytes = '0;
    enc_line_chars = 0;
  endtask

  task automatic predict_uuencode(input logic cmd, input logic [7:0] b);
    logic [11:0] acc;
    int          nbits;
    if (cmd == CMD_DATA) begin
      acc = {enc_left_bits, b};
      nbits = enc_left_cnt + 8;
      enc_line_bytes = enc_line_bytes + 6'd1;
      while (nbits >= 6) begin
        nbits -= 6;
        store_group(6'(acc >> nbits));
      end
      enc_left_cnt = 3'(nbits);
      enc_left_bits = 4'(acc & ((12'd1 << nbits) - 12'd1));
      if (nbits == 0 && enc_line_chars >= LINE_CHARS)
        push_line();
    end else begin
      // pad leftover bits with zero bytes until the groups come out even
      acc = {8'd0, enc_left_bits};
      nbits = enc_left_cnt;
      while (nbits > 0) begin
        if (nbits < 6) begin
          acc = acc << 8;
          nbits += 8;
        end
        nbits -= 6;
        store_group(6'(acc >> nbits));
        acc = acc & ((12'd1 << nbits) - 12'd1);
      end
      enc_left_bits = '0;
      enc_left_cnt = '0;
      if (enc_line_bytes == 6'd0) begin
        enc_line_chars = 0;
        expected_chars.push_back(char_t'{MARK_CHAR, 1'b1});
      end else begin
        push_line();
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_items.push_back(stim_t'{CMD_DATA, b, 1'b0});
  endtask

  task automatic queue_finish();
    pending_items.push_back(stim_t'{CMD_FINISH, 8'(($urandom_range(0, 255))), 1'b0});
  endtask

  task automatic queue_drain();
    pending_items.push_back(stim_t'{CMD_DATA, 8'd0, 1'b1});
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    stim_t nxt;
    logic  drive_v;
    logic  took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      took = in_valid && !in_stall;
      drive_v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        if (pending_items[0].drain) begin
          if (!took && pending_n == 0)
            void'(pending_items.pop_front());
        end else begin
          nxt = pending_items.pop_front();
          drive_v = 1'b1;
          in_cmd <= nxt.cmd;
          in_data_byte <= nxt.data;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              4, 5:    gap_left = $urandom_range(1, 3);
              6:       gap_left = $urandom_range(4, 12);
              7:       gap_left = $urandom_range(20, 40);
              default: gap_left = 0;
            endcase
          end
        end
      end
      in_valid <= drive_v;
    end
  end

  // receiver stall pattern, switching style every so often
  always @(posedge clk) begin
    logic s;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      1:       s = ($urandom_range(0, 2) == 0);
      2:       s = ((stall_left % 16) < 10);
      3:       s = stall_left[0];
      default: s = 1'b0;
    endcase
    out_stall <= s;
  end

  // monitor: check each output transfer, then predict from each input transfer
  always @(posedge clk) begin
    char_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output, expected none, actual char=%0d last=%0b",
                   $time, out_char, out_last_of_run);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            fail_count++;
            $display("%0t: out_char mismatch, expected %0d, actual %0d",
                     $time, want.ch, out_char);
          end
          if (out_last_of_run !== want.last) begin
            fail_count++;
            $display("%0t: out_last_of_run mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last_of_run);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_uuencode(in_cmd, in_data_byte);
    end
    pending_n <= expected_chars.size();
  end

  initial begin
    int n_items;
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_DATA;
    in_data_byte = 8'd0;
    out_stall = 1'b0;
    pending_n = 0;
    fail_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_left = 0;
    enc_left_bits = '0;
    enc_left_cnt = '0;
    enc_line_bytes = '0;
    enc_line_chars = 0;

    // finish on an empty line, twice in a row
    queue_finish();
    queue_drain();
    queue_finish();
    // one leftover byte, all zero and all ones
    queue_byte(8'h00);
    queue_finish();
    queue_byte(8'hFF);
    queue_finish();
    // two leftover bytes
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_finish();
    queue_byte(8'h80);
    queue_byte(8'h01);
    queue_finish();
    // whole groups, no leftover bits at finish
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_byte(8'h0F);
    queue_finish();
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_finish();
    queue_drain();

    // random streams: short partial lines, lines around 45 bytes, and two+ lines
    n_items = 20;
    while (n_items < 130) begin
      case ($urandom_range(0, 19))
        0:                  len = 0;
        12, 13, 14, 15, 16: len = $urandom_range(40, 50);
        17, 18, 19:         len = $urandom_range(88, 92);
        default:            len = $urandom_range(1, 20);
      endcase
      // keep the total close to the planned item count
      if (len > 129 - n_items)
        len = 129 - n_items;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       queue_byte(8'h00);
          1:       queue_byte(8'hFF);
          default: queue_byte(8'($urandom_range(0, 255)));
        endcase
      end
      queue_finish();
      if ($urandom_range(0, 3) == 0)
        queue_drain();
      n_items += len + 1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_valid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
src/uue_pkg.sv
src/uue_line_buf.sv
src/uuencode_line_encoder_core.sv
tb/sv/testbench.sv
